/* sv/sms_pkg.sv */
// shared types and constants for the semaphore / mutex sync unit
// no dependencies; used by every sms_* module and the core top level
package sms_pkg;

	localparam int MASK_W  = 16;
	localparam int PRIO_W  = 8;
	localparam int TCNT_W  = 5;
	localparam int CIDX_W  = 3;
	localparam int CDATA_W = 16;

	localparam logic [PRIO_W-1:0] PRIO_FREE = 8'hFF;

	// configuration register indexes
	localparam logic [CIDX_W-1:0] REG_THREAD_COUNT = 3'd0;
	localparam logic [CIDX_W-1:0] REG_SEM_INIT_0   = 3'd1;
	localparam logic [CIDX_W-1:0] REG_SEM_INIT_3   = 3'd4;

	typedef enum logic [2:0] {
		OP_PEND   = 3'd0,
		OP_POST   = 3'd1,
		OP_LOCK   = 3'd2,
		OP_UNLOCK = 3'd3,
		OP_SETPRI = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_GRANTED  = 3'd0,
		ST_BLOCKED  = 3'd1,
		ST_RELEASED = 3'd2,
		ST_IGNORED  = 3'd3,
		ST_POSTED   = 3'd4,
		ST_PRIO_SET = 3'd5
	} status_t;

	typedef struct packed {
		logic pend;
		logic post;
		logic load;
	} sem_cmd_t;

	typedef struct packed {
		status_t             status;
		logic                yield;
		logic [MASK_W-1:0]   woken;
		logic [MASK_W-1:0]   blocked;
		logic [PRIO_W-1:0]   opri;
	} result_t;

endpackage

/* sv/sms_prio_ram.sv */
// thread priority memory: one write port, two registered read ports
// per-entry valid bits make unwritten entries read as the free priority; uses sms_pkg
module sms_prio_ram #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       we,
	input  logic [AW-1:0]              wa,
	input  logic [sms_pkg::PRIO_W-1:0] wd,
	input  logic [AW-1:0]              ra0,
	input  logic [AW-1:0]              ra1,
	output logic [sms_pkg::PRIO_W-1:0] rd0,
	output logic [sms_pkg::PRIO_W-1:0] rd1
);

	logic [sms_pkg::PRIO_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]           vld_q;
	logic [sms_pkg::PRIO_W-1:0] rd0_q;
	logic [sms_pkg::PRIO_W-1:0] rd1_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (we) begin
			vld_q[wa] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
	end

	// write-first: a read at the address being written sees the new value
	always_ff @(posedge clk) begin
		if (we && wa == ra0) begin
			rd0_q <= wd;
		end else begin
			rd0_q <= vld_q[ra0] ? mem[ra0] : sms_pkg::PRIO_FREE;
		end
		if (we && wa == ra1) begin
			rd1_q <= wd;
		end else begin
			rd1_q <= vld_q[ra1] ? mem[ra1] : sms_pkg::PRIO_FREE;
		end
	end

	assign rd0 = rd0_q;
	assign rd1 = rd1_q;

endmodule

/* sv/sms_sem_bank.sv */
// counting semaphore bank: pend decrement, saturating post, config preload
// depends on sms_pkg for the command struct
module sms_sem_bank #(
	parameter int NUM_SEMS    = 4,
	parameter int COUNT_WIDTH = 16,
	parameter int SI_W        = 2
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  sms_pkg::sem_cmd_t           cmd,
	input  logic [SI_W-1:0]             si,
	input  logic [SI_W-1:0]             ld_idx,
	input  logic [sms_pkg::CDATA_W-1:0] ld_value,
	output logic                        nonzero
);

	logic [NUM_SEMS-1:0][COUNT_WIDTH-1:0] cnt_q;
	logic [COUNT_WIDTH-1:0]               cur;

	assign cur     = cnt_q[si];
	assign nonzero = (cur != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load) begin
			cnt_q[ld_idx] <= COUNT_WIDTH'(32'(ld_value));
		end else if (cmd.pend && nonzero) begin
			cnt_q[si] <= cur - 1'b1;
		end else if (cmd.post && cur != '1) begin
			cnt_q[si] <= cur + 1'b1;
		end
	end

endmodule

/* sv/sms_sync_ctl.sv */
// mutex table, blocked-thread bits and the per-request decision logic
// depends on sms_pkg; drives the write port of sms_prio_ram
module sms_sync_ctl #(
	parameter int MAX_THREADS = 16,
	parameter int NUM_MUTEXES = 4,
	parameter int TID_W       = 4,
	parameter int MI_W        = 2
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       vld,
	input  sms_pkg::op_t               op,
	input  logic [TID_W-1:0]           tid,
	input  logic [MI_W-1:0]            mi,
	input  logic [sms_pkg::PRIO_W-1:0] new_prio,
	input  logic [sms_pkg::PRIO_W-1:0] p_tid,
	input  logic [sms_pkg::PRIO_W-1:0] p_own,
	input  logic                       sem_nz,
	input  logic [sms_pkg::TCNT_W-1:0] thread_count,
	input  logic [MI_W-1:0]            mi_look,
	output logic [TID_W-1:0]           own_look,
	output logic                       pw_en,
	output logic [TID_W-1:0]           pw_addr,
	output logic [sms_pkg::PRIO_W-1:0] pw_data,
	output sms_pkg::result_t           res
);

	localparam int LIVE_W = (TID_W + 1 > sms_pkg::TCNT_W) ? TID_W + 1 : sms_pkg::TCNT_W + 1;

	logic [NUM_MUTEXES-1:0]                           held_q, held_d;
	logic [NUM_MUTEXES-1:0][TID_W-1:0]                owner_q, owner_d;
	logic [NUM_MUTEXES-1:0][sms_pkg::PRIO_W-1:0]      saved_q, saved_d;
	logic [MAX_THREADS-1:0]                           blk_q, blk_d;
	logic [MAX_THREADS-1:0]                           live;
	logic [MAX_THREADS-1:0]                           woken;
	logic                                             wake;
	logic [TID_W-1:0]                                 own;
	logic [TID_W-1:0]                                 own_after;
	sms_pkg::status_t                                 status;
	logic                                             yield;
	logic [sms_pkg::MASK_W-1:0]                       woken_m;
	logic [sms_pkg::MASK_W-1:0]                       blocked_m;

	// threads below thread_count take part in a wake
	for (genvar g = 0; g < MAX_THREADS; g++) begin : g_live
		assign live[g] = (LIVE_W'(thread_count) > LIVE_W'(g));
	end

	assign own = owner_q[mi];

	always_comb begin
		held_d  = held_q;
		owner_d = owner_q;
		saved_d = saved_q;
		blk_d   = blk_q;
		pw_en   = 1'b0;
		pw_addr = tid;
		pw_data = new_prio;
		status  = sms_pkg::ST_IGNORED;
		yield   = 1'b0;
		wake    = 1'b0;
		if (vld) begin
			case (op)
				sms_pkg::OP_PEND: begin
					if (sem_nz) begin
						status = sms_pkg::ST_GRANTED;
					end else begin
						blk_d[tid] = 1'b1;
						status     = sms_pkg::ST_BLOCKED;
						yield      = 1'b1;
					end
				end
				sms_pkg::OP_POST: begin
					wake   = 1'b1;
					status = sms_pkg::ST_POSTED;
					yield  = 1'b1;
				end
				sms_pkg::OP_LOCK: begin
					if (!held_q[mi]) begin
						held_d[mi]  = 1'b1;
						owner_d[mi] = tid;
						saved_d[mi] = p_tid;
						status      = sms_pkg::ST_GRANTED;
					end else begin
						// priority inheritance: owner takes the more urgent caller priority
						if (p_tid < p_own) begin
							pw_en   = 1'b1;
							pw_addr = own;
							pw_data = p_tid;
						end
						blk_d[tid] = 1'b1;
						status     = sms_pkg::ST_BLOCKED;
						yield      = 1'b1;
					end
				end
				sms_pkg::OP_UNLOCK: begin
					if (held_q[mi] && own == tid) begin
						pw_en      = 1'b1;
						pw_data    = saved_q[mi];
						held_d[mi] = 1'b0;
						wake       = 1'b1;
						status     = sms_pkg::ST_RELEASED;
						yield      = 1'b1;
					end
				end
				sms_pkg::OP_SETPRI: begin
					pw_en  = 1'b1;
					status = sms_pkg::ST_PRIO_SET;
				end
				default: begin
					status = sms_pkg::ST_IGNORED;
				end
			endcase
		end
		woken = wake ? (blk_q & live) : '0;
		blk_d = blk_d & ~woken;
	end

	assign own_look  = owner_d[mi_look];
	assign own_after = owner_d[mi];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= '0;
			owner_q <= '0;
			saved_q <= {NUM_MUTEXES{sms_pkg::PRIO_FREE}};
			blk_q   <= '0;
		end else begin
			held_q  <= held_d;
			owner_q <= owner_d;
			saved_q <= saved_d;
			blk_q   <= blk_d;
		end
	end

	always_comb begin
		res.status  = status;
		res.yield   = yield;
		res.woken   = woken_m;
		res.blocked = blocked_m;
		if (!held_d[mi]) begin
			res.opri = sms_pkg::PRIO_FREE;
		end else if (pw_en && pw_addr == own_after) begin
			res.opri = pw_data;
		end else if (own_after == tid) begin
			res.opri = p_tid;
		end else begin
			res.opri = p_own;
		end
	end

	for (genvar g = 0; g < sms_pkg::MASK_W; g++) begin : g_mask
		if (g < MAX_THREADS) begin : g_in
			assign woken_m[g]   = woken[g];
			assign blocked_m[g] = blk_d[g];
		end else begin : g_out
			assign woken_m[g]   = 1'b0;
			assign blocked_m[g] = 1'b0;
		end
	end

endmodule

/* sv/semaphore_mutex_sync_unit_core.sv */
// top level of the semaphore / mutex sync unit: request register, state tables, result register
// depends on sms_pkg, sms_prio_ram, sms_sem_bank and sms_sync_ctl
//
// channel   direction  handshake               payload
// request   in         start, busy             op, thread_id, object_index, new_priority
// result    out        done (one-cycle strobe) status, yield_request, woken_mask,
//                                              blocked_mask, owner_priority
// config    in         cfg_valid, cfg_ready    cfg_index, cfg_data
//
// one request per cycle; busy stays low, so start alone accepts a request
// the accepting edge loads the request register; the result register and done are loaded from it
// after one read-modify-write pass over the state tables, so done rises together with the result
// the thread priority memory is read at acceptance and forwarded from the pass in flight
// reset clears all tables at once; results cannot be stalled and are never dropped
module semaphore_mutex_sync_unit_core #(
	parameter int MAX_THREADS = 16,
	parameter int NUM_SEMS    = 4,
	parameter int NUM_MUTEXES = 4,
	parameter int COUNT_WIDTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [2:0]                   op,
	input  logic [3:0]                   thread_id,
	input  logic [1:0]                   object_index,
	input  logic [7:0]                   new_priority,
	output logic                         done,
	output logic [2:0]                   status,
	output logic                         yield_request,
	output logic [15:0]                  woken_mask,
	output logic [15:0]                  blocked_mask,
	output logic [7:0]                   owner_priority,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [sms_pkg::CIDX_W-1:0]   cfg_index,
	input  logic [sms_pkg::CDATA_W-1:0]  cfg_data
);

	localparam int TID_W = $clog2(MAX_THREADS);
	localparam int SI_W  = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
	localparam int MI_W  = (NUM_MUTEXES > 1) ? $clog2(NUM_MUTEXES) : 1;

	logic [TID_W-1:0] tid_map [16];
	logic [SI_W-1:0]  si_map  [4];
	logic [MI_W-1:0]  mi_map  [4];

	logic [TID_W-1:0] tid_in;
	logic [MI_W-1:0]  mi_in;
	logic [TID_W-1:0] own_look;
	logic             accept;
	logic             cfg_wr;

	logic                       valid_s1;
	sms_pkg::op_t               op_s1;
	logic [TID_W-1:0]           tid_s1;
	logic [SI_W-1:0]            si_s1;
	logic [MI_W-1:0]            mi_s1;
	logic [sms_pkg::PRIO_W-1:0] prio_s1;

	logic [sms_pkg::PRIO_W-1:0] p_tid;
	logic [sms_pkg::PRIO_W-1:0] p_own;
	logic                       pw_en;
	logic [TID_W-1:0]           pw_addr;
	logic [sms_pkg::PRIO_W-1:0] pw_data;

	logic [sms_pkg::TCNT_W-1:0] thread_count_q;
	sms_pkg::sem_cmd_t          sem_cmd;
	logic [SI_W-1:0]            ld_idx;
	logic                       sem_nz;

	sms_pkg::result_t res;
	sms_pkg::result_t res_s2;
	logic             done_s2;

	// index folding onto the configured table sizes
	for (genvar g = 0; g < 16; g++) begin : g_tid
		assign tid_map[g] = TID_W'(g % MAX_THREADS);
	end
	for (genvar g = 0; g < 4; g++) begin : g_obj
		assign si_map[g] = SI_W'(g % NUM_SEMS);
		assign mi_map[g] = MI_W'(g % NUM_MUTEXES);
	end

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign tid_in    = tid_map[thread_id];
	assign mi_in     = mi_map[object_index];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= sms_pkg::op_t'(op);
			tid_s1  <= tid_in;
			si_s1   <= si_map[object_index];
			mi_s1   <= mi_in;
			prio_s1 <= new_priority;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thread_count_q <= sms_pkg::TCNT_W'(16);
		end else if (cfg_wr && cfg_index == sms_pkg::REG_THREAD_COUNT) begin
			thread_count_q <= cfg_data[sms_pkg::TCNT_W-1:0];
		end
	end

	always_comb begin
		sem_cmd.pend = valid_s1 && op_s1 == sms_pkg::OP_PEND;
		sem_cmd.post = valid_s1 && op_s1 == sms_pkg::OP_POST;
		sem_cmd.load = 1'b0;
		ld_idx       = SI_W'(cfg_index - sms_pkg::REG_SEM_INIT_0);
		if (cfg_wr && cfg_index >= sms_pkg::REG_SEM_INIT_0 &&
		    cfg_index <= sms_pkg::REG_SEM_INIT_3 &&
		    int'(cfg_index - sms_pkg::REG_SEM_INIT_0) < NUM_SEMS) begin
			sem_cmd.load = 1'b1;
		end
	end

	sms_sem_bank #(
		.NUM_SEMS    (NUM_SEMS),
		.COUNT_WIDTH (COUNT_WIDTH),
		.SI_W        (SI_W)
	) u_sem (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (sem_cmd),
		.si       (si_s1),
		.ld_idx   (ld_idx),
		.ld_value (cfg_data),
		.nonzero  (sem_nz)
	);

	sms_prio_ram #(
		.DEPTH (MAX_THREADS),
		.AW    (TID_W)
	) u_prio (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (pw_en),
		.wa     (pw_addr),
		.wd     (pw_data),
		.ra0    (tid_in),
		.ra1    (own_look),
		.rd0    (p_tid),
		.rd1    (p_own)
	);

	sms_sync_ctl #(
		.MAX_THREADS (MAX_THREADS),
		.NUM_MUTEXES (NUM_MUTEXES),
		.TID_W       (TID_W),
		.MI_W        (MI_W)
	) u_ctl (
		.clk          (clk),
		.arst_n       (arst_n),
		.vld          (valid_s1),
		.op           (op_s1),
		.tid          (tid_s1),
		.mi           (mi_s1),
		.new_prio     (prio_s1),
		.p_tid        (p_tid),
		.p_own        (p_own),
		.sem_nz       (sem_nz),
		.thread_count (thread_count_q),
		.mi_look      (mi_in),
		.own_look     (own_look),
		.pw_en        (pw_en),
		.pw_addr      (pw_addr),
		.pw_data      (pw_data),
		.res          (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			res_s2 <= res;
		end
	end

	assign done           = done_s2;
	assign status         = res_s2.status;
	assign yield_request  = res_s2.yield;
	assign woken_mask     = res_s2.woken;
	assign blocked_mask   = res_s2.blocked;
	assign owner_priority = res_s2.opri;

endmodule
